// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked property, disabled while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// clocked property, checked during reset too
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/aot_pkg.sv -----
`timescale 1ns / 1ps
package aot_pkg;

  // register field widths
  localparam int TRIG_W    = 15;
  localparam int HOLD_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_POS_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_SAMPLES = 1'd1;

  // reset values
  localparam logic [TRIG_W-1:0] TRIG_RESET = 15'd16384;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd4800;

endpackage

// ----- rtl/aot_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aot_core #(
  parameter int SAMPLE_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           stream_end,
  input  logic [aot_pkg::TRIG_W-1:0]     trigger_level,
  input  logic [aot_pkg::HOLD_W-1:0]     holdoff_samples,
  output logic                           emit,
  output logic [aot_pkg::OUT_POS_W-1:0]  res_position,
  output logic signed [SAMPLE_BITS-1:0]  res_sample
);

  localparam int MAG_W = SAMPLE_BITS + 1;

  logic [POSITION_BITS-1:0]   position_count, position_count_next;
  logic [aot_pkg::HOLD_W-1:0] holdoff_left, holdoff_left_next;
  logic [aot_pkg::HOLD_W-1:0] window_left, window_left_next;
  logic [MAG_W-1:0]           best_magnitude, best_magnitude_next;
  logic [POSITION_BITS-1:0]   best_position, best_position_next;
  logic [SAMPLE_BITS-1:0]     best_value, best_value_next;

  logic                       neg;
  logic [MAG_W-1:0]           mag;
  logic                       trig;
  logic [aot_pkg::HOLD_W-1:0] len;
  logic                       emit_c;

  // magnitude and trigger decision
  assign neg = sample[SAMPLE_BITS-1];
  assign mag = neg ? ({1'b0, ~sample} + 1'b1) : {1'b0, sample};
  assign trig = !neg && (holdoff_left == '0) &&
                ({{aot_pkg::TRIG_W{1'b0}}, sample} >=
                 {{SAMPLE_BITS{1'b0}}, trigger_level});
  assign len = (holdoff_samples == '0) ? aot_pkg::HOLD_W'(1) : holdoff_samples;

  // next state for one word
  always_comb begin
    holdoff_left_next   = holdoff_left;
    window_left_next    = window_left;
    best_magnitude_next = best_magnitude;
    best_position_next  = best_position;
    best_value_next     = best_value;
    position_count_next = position_count + 1'b1;
    emit_c              = 1'b0;

    if (trig) begin
      best_magnitude_next = mag;
      best_position_next  = position_count;
      best_value_next     = sample;
      holdoff_left_next   = len;
      window_left_next    = len - 1'b1;
      if (window_left_next == '0) emit_c = 1'b1;
    end else begin
      if (holdoff_left != '0) holdoff_left_next = holdoff_left - 1'b1;
      if (window_left != '0) begin
        // strict compare keeps the first index on ties
        if (mag > best_magnitude) begin
          best_magnitude_next = mag;
          best_position_next  = position_count;
          best_value_next     = sample;
        end
        window_left_next = window_left - 1'b1;
        if (window_left_next == '0) emit_c = 1'b1;
      end
    end

    // stream end flushes an open window
    if (stream_end && window_left_next != '0) emit_c = 1'b1;
    if (emit_c) window_left_next = '0;

    res_position = aot_pkg::OUT_POS_W'(best_position_next);
    res_sample   = best_value_next;

    // stream end clears position, counters and peak
    if (stream_end) begin
      position_count_next = '0;
      holdoff_left_next   = '0;
      window_left_next    = '0;
      best_magnitude_next = '0;
      best_position_next  = '0;
      best_value_next     = '0;
    end
  end

  assign emit = accept && emit_c;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      holdoff_left   <= '0;
      window_left    <= '0;
      best_magnitude <= '0;
      best_position  <= '0;
      best_value     <= '0;
    end else if (accept) begin
      position_count <= position_count_next;
      holdoff_left   <= holdoff_left_next;
      window_left    <= window_left_next;
      best_magnitude <= best_magnitude_next;
      best_position  <= best_position_next;
      best_value     <= best_value_next;
    end
  end

  // window never outlives its hold-off
  `ASSERT_CLK(a_window_in_holdoff, clk, rst, (window_left == '0) || (window_left < holdoff_left))
  // a result always closes the window
  `ASSERT_CLK(a_emit_closes, clk, rst, emit |=> (window_left == '0))
  // stream end restarts the position count
  `ASSERT_CLK(a_end_restarts, clk, rst, (accept && stream_end) |=> (position_count == '0))

endmodule

// ----- rtl/audio_onset_trigger_peak_hold_top.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Onset trigger with retrigger hold-off and peak hold.
// Input stream: one signed sample per word on s_tdata, s_tlast marks the
// final sample of a stream. A sample at or above trigger_level with no
// hold-off running opens a window of holdoff_samples samples starting with
// that sample and loads an equal dead time. Output stream: one word per
// closed window (or per stream end with a window open) carrying the
// absolute position and signed value of the first largest magnitude.
// Configuration: cfg_wen writes cfg_data into register cfg_index
// (0 trigger_level, 1 holdoff_samples); write only while idle.
// Throughput: one sample per cycle while s_tready is high, set by the
// combinational compare and count path between the input handshake and the
// output register. The result of the window-closing sample is registered
// into the output register (via the skid word when stalled) for m_tvalid.
// Stall: an output register plus one skid word; s_tready drops only while
// the skid word is occupied, and rises once the receiver takes a word.
// Reset: position and counters go to zero, trigger_level to 16384 and
// holdoff_samples to 4800; no result is pending.
module audio_onset_trigger_peak_hold_top #(
  parameter int SAMPLE_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,  // sample
  input  logic                              s_tlast,  // stream_end
  // result words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [((aot_pkg::OUT_POS_W+SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // peak_position, peak_sample
  // configuration
  input  logic                              cfg_wen,
  input  logic [aot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aot_pkg::CFG_W-1:0]         cfg_data
);

  localparam int RES_W = aot_pkg::OUT_POS_W + SAMPLE_BITS;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  logic [aot_pkg::TRIG_W-1:0] trigger_level;
  logic [aot_pkg::HOLD_W-1:0] holdoff_samples;

  logic                             accept;
  logic                             emit;
  logic [aot_pkg::OUT_POS_W-1:0]    res_position;
  logic signed [SAMPLE_BITS-1:0]    res_sample;
  logic [RES_W-1:0]                 res_word;

  logic                             out_valid;
  logic [RES_W-1:0]                 out_word;
  logic                             skid_valid;
  logic [RES_W-1:0]                 skid_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level   <= aot_pkg::TRIG_RESET;
      holdoff_samples <= aot_pkg::HOLD_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        aot_pkg::REG_TRIGGER_LEVEL:   trigger_level   <= cfg_data[aot_pkg::TRIG_W-1:0];
        aot_pkg::REG_HOLDOFF_SAMPLES: holdoff_samples <= cfg_data[aot_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  aot_core #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .sample          (s_tdata[SAMPLE_BITS-1:0]),
    .stream_end      (s_tlast),
    .trigger_level   (trigger_level),
    .holdoff_samples (holdoff_samples),
    .emit            (emit),
    .res_position    (res_position),
    .res_sample      (res_sample)
  );

  assign res_word = {res_sample, res_position};

  // output register with one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || m_tready) begin
      out_valid <= emit;
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) out_word <= skid_word;
    end else if (!out_valid || m_tready) begin
      out_word <= res_word;
    end else if (emit) begin
      skid_word <= res_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_word);

  // skid word only fills behind a held output word
  `ASSERT_CLK(a_skid_behind_out, clk, rst, !skid_valid || out_valid)
  // skid fills only when the receiver stalled a full output register
  `ASSERT_CLK(a_skid_on_stall, clk, rst, $rose(skid_valid) |-> $past(out_valid && !m_tready))

endmodule

// ----- tb/onset_peak_checker.sv -----
`timescale 1ns / 1ps
// watches the sample, result and configuration ports, predicts the peak
// words from its own copy of the trigger state and compares them in order
module onset_peak_checker
  import aot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [15:0]          s_tdata,  // sample
  input  logic                 s_tlast,  // stream_end
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [47:0]          m_tdata,  // peak_position, peak_sample
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   error_count,
  output int                   peaks_pending
);

  typedef struct packed {
    logic [31:0]        position;
    logic signed [15:0] value;
  } peak_word_t;

  // configuration copy
  logic [TRIG_W-1:0] trig_level;
  logic [HOLD_W-1:0] hold_len;

  // trigger and peak state
  logic [31:0]        sample_pos;
  logic [15:0]        dead_left;
  logic [15:0]        win_left;
  logic [16:0]        best_mag;
  logic [31:0]        best_pos;
  logic signed [15:0] best_val;

  peak_word_t peak_fifo[$];

  // advance the trigger state by one sample, returns 1 when a peak word is due
  function automatic bit track_peak(input logic [15:0] smp, input logic last,
                                    output peak_word_t pk);
    logic        neg;
    logic [16:0] mag;
    logic [15:0] len;
    bit          fire;
    neg  = smp[15];
    mag  = neg ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    fire = 1'b0;
    pk   = '0;
    if (!neg && smp >= {1'b0, trig_level} && dead_left == 16'd0) begin
      // trigger sample seeds the peak
      len       = (hold_len == '0) ? 16'd1 : hold_len;
      best_mag  = mag;
      best_pos  = sample_pos;
      best_val  = smp;
      dead_left = len;
      win_left  = len - 16'd1;
      if (win_left == 16'd0) fire = 1'b1;
    end else begin
      if (dead_left != 16'd0) dead_left = dead_left - 16'd1;
      if (win_left != 16'd0) begin
        // first largest magnitude wins
        if (mag > best_mag) begin
          best_mag = mag;
          best_pos = sample_pos;
          best_val = smp;
        end
        win_left = win_left - 16'd1;
        if (win_left == 16'd0) fire = 1'b1;
      end
    end
    // stream end flushes an open window
    if (last && win_left != 16'd0) fire = 1'b1;
    if (fire) begin
      pk.position = best_pos;
      pk.value    = best_val;
      win_left    = 16'd0;
    end
    if (last) begin
      sample_pos = '0;
      dead_left  = '0;
      win_left   = '0;
      best_mag   = '0;
      best_pos   = '0;
      best_val   = '0;
    end else begin
      sample_pos = sample_pos + 32'd1;
    end
    return fire;
  endfunction

  always @(posedge clk) begin
    peak_word_t want;
    peak_word_t got;
    if (rst) begin
      trig_level  = TRIG_RESET;
      hold_len    = HOLD_RESET;
      sample_pos  = '0;
      dead_left   = '0;
      win_left    = '0;
      best_mag    = '0;
      best_pos    = '0;
      best_val    = '0;
      error_count = 0;
      peak_fifo.delete();
    end else begin
      // register writes
      if (cfg_wen) begin
        case (cfg_index)
          REG_TRIGGER_LEVEL:   trig_level = cfg_data[TRIG_W-1:0];
          REG_HOLDOFF_SAMPLES: hold_len   = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
      // compare the result word against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.position = m_tdata[31:0];
        got.value    = m_tdata[47:32];
        if (peak_fifo.size() == 0) begin
          $display("%0t: unexpected peak word, expected none, got pos %0d value %0d",
                   $time, got.position, got.value);
          error_count = error_count + 1;
        end else begin
          want = peak_fifo.pop_front();
          if (got.position !== want.position) begin
            $display("%0t: peak_position expected %0d got %0d",
                     $time, want.position, got.position);
            error_count = error_count + 1;
          end
          if (got.value !== want.value) begin
            $display("%0t: peak_sample expected %0d got %0d",
                     $time, want.value, got.value);
            error_count = error_count + 1;
          end
        end
      end
      // predict from the accepted sample
      if (s_tvalid && s_tready) begin
        if (track_peak(s_tdata, s_tlast, want)) peak_fifo.push_back(want);
      end
    end
    peaks_pending = peak_fifo.size();
  end

endmodule

// ----- tb/tb_audio_onset_trigger_peak_hold_top.sv -----
`timescale 1ns / 1ps
module tb_audio_onset_trigger_peak_hold_top;
  import aot_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [15:0]          s_tdata;  // sample
  logic                 s_tlast;  // stream_end
  logic                 m_tvalid;
  logic                 m_tready;
  logic [47:0]          m_tdata;  // peak_position, peak_sample
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int error_count;
  int peaks_pending;
  int send_idle;
  int recv_idle;

  audio_onset_trigger_peak_hold_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  onset_peak_checker peak_chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .peaks_pending(peaks_pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // entered and left right after a falling edge with nothing driven yet
  task automatic send_sample(input int smp, input bit last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp[15:0];
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every predicted peak word has come out
  task automatic drain_peaks();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (peaks_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both registers
  task automatic write_regs(input int level, input int hold);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_TRIGGER_LEVEL;
    cfg_data  <= CFG_W'(level);
    @(negedge clk);
    cfg_index <= REG_HOLDOFF_SAMPLES;
    cfg_data  <= CFG_W'(hold);
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // mix of quiet noise, hits, tie values and full range words
  function automatic int pick_sample(input int level);
    int r;
    int mag;
    r = $urandom_range(99);
    if (r < 15) return int'($signed(16'($urandom())));
    if (r < 35) return $urandom_range(32767, level);
    if (r < 45) return $urandom_range(1) ? level : -level;
    mag = $urandom_range(level - 1, 0);
    return $urandom_range(1) ? mag : -mag;
  endfunction

  initial begin
    int level;
    int hold;
    int end_odds;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_wen   = 1'b0;
    cfg_index = REG_TRIGGER_LEVEL;
    cfg_data  = '0;
    send_idle = 23;
    recv_idle = 83;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // window of three, exact threshold, most negative peak, ties,
    // window close together with stream end
    write_regs(100, 3);
    send_sample(50, 0);
    send_sample(100, 0);
    send_sample(-32768, 0);
    send_sample(32767, 0);
    send_sample(200, 0);
    send_sample(200, 0);
    send_sample(-200, 0);
    send_sample(0, 1);
    send_sample(-1, 0);
    send_sample(0, 0);
    drain_peaks();

    // zero hold-off acts as one, lowest threshold
    write_regs(1, 0);
    send_sample(1, 0);
    send_sample(1, 0);
    send_sample(1, 0);
    send_sample(0, 1);
    drain_peaks();

    // highest threshold, longest window flushed by stream end
    write_regs(32767, 65535);
    send_sample(32766, 0);
    send_sample(32767, 0);
    send_sample(-32767, 0);
    send_sample(5, 1);
    drain_peaks();

    // new settings while a window is open
    write_regs(1000, 10);
    send_sample(5000, 0);
    send_sample(-6000, 0);
    drain_peaks();
    write_regs(2000, 2);
    send_sample(7000, 1);
    drain_peaks();

    // random phases
    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 3) begin
        send_idle = 23;
        recv_idle = 83;
      end else if (phase < 6) begin
        send_idle = 83;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (phase)
        0: begin level = 1;     hold = 1;     end
        1: begin level = 32767; hold = 65535; end
        2: begin level = $urandom_range(30000, 1000); hold = 0; end
        default: begin
          level = $urandom_range(30000, 1000);
          hold  = $urandom_range(40, 2);
        end
      endcase
      end_odds = (hold > 1000) ? 7 : 63;
      write_regs(level, hold);
      for (int k = 0; k < 200; k++) begin
        send_sample(pick_sample(level), $urandom_range(end_odds) == 0);
      end
      drain_peaks();
    end

    // final flush and verdict
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (peaks_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (error_count == 0 && peaks_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
